>>> rtl/core/luf_pkg.sv
// luf_pkg: shared types, codes and constants of the static-pivot LU engine
// no dependencies; imported by luf_fpu, lu_factorization_static_pivot and tb
`default_nettype none

package luf_pkg;

   // matrix store geometry
   localparam int MAX_DIM   = 64;
   localparam int IDX_W     = 7;
   localparam int POS_W     = 6;
   localparam int ADDR_W    = 2 * POS_W;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;

   // floating point datapath
   localparam int SIG_W     = 108;
   localparam int EXP_W     = 13;
   localparam int DIV_STEPS = 58;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

   localparam logic [6:0] CNT_MAX = 7'd127;

   // function codes of a request word
   localparam logic [1:0] FN_WRITE  = 2'd0;
   localparam logic [1:0] FN_FACTOR = 2'd1;
   localparam logic [1:0] FN_READ   = 2'd2;

   // register indexes of the csr port
   localparam logic [1:0] CSR_SIZE   = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;
   localparam logic [1:0] CSR_ENABLE = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [63:0] value;
   } luf_req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic [6:0]  replaced_pivots;
   } luf_rsp_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_SUB,
      OP_RCP
   } luf_op_type;

   typedef struct packed {
      logic        start;
      luf_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
   } luf_fpu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } luf_fpu_rslt_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_ADD,
      F_DNRM,
      F_DIV,
      F_NORM,
      F_ROUND
   } luf_fpu_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_RCP_WAIT,
      ST_L_RD,
      ST_L_GO,
      ST_L_WAIT,
      ST_U_RD,
      ST_U_GET,
      ST_P_RD,
      ST_P_GO,
      ST_P_WAIT,
      ST_A_RD,
      ST_A_GO,
      ST_A_WAIT,
      ST_COL_NEXT,
      ST_DONE
   } luf_state_type;

endpackage

`default_nettype wire

>>> rtl/core/luf_fpu.sv
// luf_fpu: shared double precision unit for multiply, subtract and reciprocal
// iterative: 32x32 partial products, one quotient bit a cycle, stepwise normalise
// depends on luf_pkg
`default_nettype none

module luf_fpu import luf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  luf_fpu_cmd_type  cmd,
   output luf_fpu_rslt_type rslt
);

   luf_fpu_state_type state_ff, state_in;
   logic                    sgn_ff, sgn_in;
   logic [SIG_W-1:0]        sig_ff, sig_in;
   logic [SIG_W-1:0]        yv_ff, yv_in;
   logic                    esub_ff, esub_in;
   logic signed [EXP_W-1:0] ex_ff, ex_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [52:0]             ma_ff, ma_in;
   logic [52:0]             mb_ff, mb_in;
   logic [63:0]             prod_ff, prod_in;
   logic [53:0]             rem_ff, rem_in;
   logic [63:0]             res_ff, res_in;
   logic                    done_ff, done_in;

   // operand fields
   logic                    a_sgn, b_sgn;
   logic [52:0]             a_man, b_man;
   logic signed [EXP_W-1:0] a_eff, b_eff;
   logic                    a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   always_comb begin
      a_sgn  = cmd.a[63];
      b_sgn  = cmd.b[63];
      a_man  = {cmd.a[62:52] != 11'd0, cmd.a[51:0]};
      b_man  = {cmd.b[62:52] != 11'd0, cmd.b[51:0]};
      a_eff  = (cmd.a[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, cmd.a[62:52]});
      b_eff  = (cmd.b[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, cmd.b[62:52]});
      a_nan  = (cmd.a[62:52] == 11'h7FF) && (cmd.a[51:0] != 52'd0);
      b_nan  = (cmd.b[62:52] == 11'h7FF) && (cmd.b[51:0] != 52'd0);
      a_inf  = (cmd.a[62:52] == 11'h7FF) && (cmd.a[51:0] == 52'd0);
      b_inf  = (cmd.b[62:52] == 11'h7FF) && (cmd.b[51:0] == 52'd0);
      a_zero = (cmd.a[62:0] == 63'd0);
      b_zero = (cmd.b[62:0] == 63'd0);
   end

   // alignment of the smaller operand for a subtract
   logic                    big_a;
   logic signed [EXP_W-1:0] e_big, e_sml, e_diff;
   logic [52:0]             m_big, m_sml;
   logic [6:0]              sh;
   logic [SIG_W-1:0]        y_full, y_shift;
   logic                    y_lost;

   always_comb begin
      big_a   = (a_eff > b_eff) || ((a_eff == b_eff) && (a_man >= b_man));
      e_big   = big_a ? a_eff : b_eff;
      e_sml   = big_a ? b_eff : a_eff;
      m_big   = big_a ? a_man : b_man;
      m_sml   = big_a ? b_man : a_man;
      e_diff  = e_big - e_sml;
      sh      = (e_diff > 13'sd127) ? 7'd127 : e_diff[6:0];
      y_full  = {1'b0, m_sml, 54'd0};
      y_shift = y_full >> sh;
      y_lost  = |(y_full & ~({SIG_W{1'b1}} << sh));
   end

   // partial product multiplier and accumulator alignment
   logic [31:0]      mul_x, mul_y;
   logic [6:0]       acc_sh;
   logic [SIG_W-1:0] addend;

   always_comb begin
      mul_x = cnt_ff[1] ? {11'd0, ma_ff[52:32]} : ma_ff[31:0];
      mul_y = cnt_ff[0] ? {11'd0, mb_ff[52:32]} : mb_ff[31:0];
      case (cnt_ff)
         6'd1:    acc_sh = 7'd0;
         6'd2:    acc_sh = 7'd32;
         6'd3:    acc_sh = 7'd32;
         6'd4:    acc_sh = 7'd64;
         default: acc_sh = 7'd0;
      endcase
      addend = {44'd0, prod_ff} << acc_sh;
   end

   // restoring division step
   logic        rem_ge;
   logic [53:0] rem_sub;

   always_comb begin
      rem_ge  = rem_ff >= {1'b0, mb_ff};
      rem_sub = rem_ge ? (rem_ff - {1'b0, mb_ff}) : rem_ff;
   end

   // round to nearest even and pack
   logic [52:0]             rnd_top;
   logic                    rnd_inc;
   logic [53:0]             rnd_sum;
   logic [52:0]             rnd_man;
   logic signed [EXP_W-1:0] rnd_ex;
   logic                    rnd_ovf;

   always_comb begin
      rnd_top = sig_ff[107:55];
      rnd_inc = sig_ff[54] && ((|sig_ff[53:0]) || rnd_top[0]);
      rnd_sum = {1'b0, rnd_top} + {53'd0, rnd_inc};
      rnd_man = rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
      rnd_ex  = rnd_sum[53] ? (ex_ff + 13'sd1) : ex_ff;
      rnd_ovf = (sig_ff != '0) && (rnd_ex >= 13'sd2047);
   end

   // sequencer of the unit
   always_comb begin
      state_in = state_ff;
      sgn_in   = sgn_ff;
      sig_in   = sig_ff;
      yv_in    = yv_ff;
      esub_in  = esub_ff;
      ex_in    = ex_ff;
      cnt_in   = cnt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_MUL: begin
                     if (a_nan) begin
                        res_in = cmd.a | QUIET_BIT;  done_in = 1'b1;
                     end else if (b_nan) begin
                        res_in = cmd.b | QUIET_BIT;  done_in = 1'b1;
                     end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                        res_in = DEFAULT_NAN;  done_in = 1'b1;
                     end else if (a_inf || b_inf) begin
                        res_in = {a_sgn ^ b_sgn, 11'h7FF, 52'd0};  done_in = 1'b1;
                     end else if (a_zero || b_zero) begin
                        res_in = {a_sgn ^ b_sgn, 63'd0};  done_in = 1'b1;
                     end else begin
                        ma_in    = a_man;
                        mb_in    = b_man;
                        sgn_in   = a_sgn ^ b_sgn;
                        ex_in    = a_eff + b_eff - 13'sd1020;
                        sig_in   = '0;
                        cnt_in   = 6'd0;
                        state_in = F_MUL;
                     end
                  end
                  OP_SUB: begin
                     if (a_nan) begin
                        res_in = cmd.a | QUIET_BIT;  done_in = 1'b1;
                     end else if (b_nan) begin
                        res_in = cmd.b | QUIET_BIT;  done_in = 1'b1;
                     end else if (a_inf && b_inf && (a_sgn == b_sgn)) begin
                        res_in = DEFAULT_NAN;  done_in = 1'b1;
                     end else if (a_inf) begin
                        res_in = cmd.a;  done_in = 1'b1;
                     end else if (b_inf) begin
                        res_in = {~b_sgn, cmd.b[62:0]};  done_in = 1'b1;
                     end else begin
                        sig_in   = {1'b0, m_big, 54'd0};
                        yv_in    = {y_shift[SIG_W-1:1], y_shift[0] | y_lost};
                        esub_in  = (a_sgn == b_sgn);
                        sgn_in   = big_a ? a_sgn : ~b_sgn;
                        ex_in    = e_big + 13'sd1;
                        state_in = F_ADD;
                     end
                  end
                  OP_RCP: begin
                     if (a_nan) begin
                        res_in = cmd.a | QUIET_BIT;  done_in = 1'b1;
                     end else if (a_zero) begin
                        res_in = {a_sgn, 11'h7FF, 52'd0};  done_in = 1'b1;
                     end else if (a_inf) begin
                        res_in = {a_sgn, 63'd0};  done_in = 1'b1;
                     end else begin
                        mb_in    = a_man;
                        ex_in    = a_eff;
                        sgn_in   = a_sgn;
                        state_in = F_DNRM;
                     end
                  end
                  default: begin
                     res_in  = DEFAULT_NAN;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         // four partial products, each added in the cycle after it is formed
         F_MUL: begin
            prod_in = mul_x * mul_y;
            if (cnt_ff != 6'd0) begin
               sig_in = sig_ff + addend;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) begin
               state_in = F_NORM;
            end
         end
         F_ADD: begin
            sig_in = esub_ff ? (sig_ff - yv_ff) : (sig_ff + yv_ff);
            if (esub_ff && (sig_ff == yv_ff)) begin
               sgn_in = 1'b0;
            end
            state_in = F_NORM;
         end
         // bring a subnormal divisor to a leading one
         F_DNRM: begin
            if (!mb_ff[52]) begin
               mb_in = {mb_ff[51:0], 1'b0};
               ex_in = ex_ff - 13'sd1;
            end else begin
               rem_in   = 54'd1 << 52;
               sig_in   = '0;
               cnt_in   = 6'd0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = {rem_sub[52:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               sig_in   = {sig_ff[DIV_STEPS-2:0], rem_ge, rem_sub != 54'd0, 49'd0};
               ex_in    = 13'sd2046 - ex_ff;
               state_in = F_NORM;
            end else begin
               sig_in = {sig_ff[SIG_W-2:0], rem_ge};
            end
         end
         // coarse and fine shifts until the leading one or the subnormal range
         F_NORM: begin
            if (sig_ff == '0) begin
               state_in = F_ROUND;
            end else if (ex_ff <= -13'sd108) begin
               sig_in = {{(SIG_W-1){1'b0}}, 1'b1};
               ex_in  = 13'sd1;
            end else if (ex_ff <= -13'sd15) begin
               sig_in = {16'd0, sig_ff[SIG_W-1:17], sig_ff[16] | (|sig_ff[15:0])};
               ex_in  = ex_ff + 13'sd16;
            end else if (ex_ff < 13'sd1) begin
               sig_in = {1'b0, sig_ff[SIG_W-1:2], sig_ff[1] | sig_ff[0]};
               ex_in  = ex_ff + 13'sd1;
            end else if ((sig_ff[107:92] == 16'd0) && (ex_ff > 13'sd16)) begin
               sig_in = {sig_ff[SIG_W-17:0], 16'd0};
               ex_in  = ex_ff - 13'sd16;
            end else if (!sig_ff[SIG_W-1] && (ex_ff > 13'sd1)) begin
               sig_in = {sig_ff[SIG_W-2:0], 1'b0};
               ex_in  = ex_ff - 13'sd1;
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (rnd_ovf) begin
               res_in = {sgn_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sgn_ff, rnd_man[52] ? rnd_ex[10:0] : 11'd0, rnd_man[51:0]};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sgn_ff  <= sgn_in;
      sig_ff  <= sig_in;
      yv_ff   <= yv_in;
      esub_ff <= esub_in;
      ex_ff   <= ex_in;
      cnt_ff  <= cnt_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign rslt.done  = done_ff;
   assign rslt.value = res_ff;

endmodule

`default_nettype wire

>>> rtl/core/lu_factorization_static_pivot.sv
// lu_factorization_static_pivot: top level with matrix store and column sequencer
// depends on luf_pkg and luf_fpu
`default_nettype none

// In-place LU factorisation of a 64x64 store of IEEE doubles, no row exchanges,
// with static pivoting. A write word is answered with no wait state; a read word
// goes through ST_RD_WAIT (registered store read). A factorise word runs column
// by column through one shared floating point unit and the one store: per column
// the pivot test and the 58-step reciprocal, then each element below the diagonal
// scaled and each trailing element updated (multiply of four partial products,
// then subtract, each with its stepwise normalise). The store needs no clearing
// pass. The block is not ready while a read or factorise runs; a finished
// response word waits in an output register.
module lu_factorization_static_pivot import luf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  luf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output luf_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   luf_state_type    state_ff, state_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] l_ff, l_in;
   logic [63:0]      r_ff, r_in;
   logic [63:0]      u_ff, u_in;
   logic [63:0]      p_ff, p_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   luf_rsp_type      rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0] size_ff;
   logic [63:0]      thresh_ff;
   logic             spen_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [63:0]       mem_wd;
   logic [63:0]       rdata_ff;
   logic [63:0]       mem [0:DEPTH-1];

   luf_fpu_cmd_type  fpu_cmd;
   luf_fpu_rslt_type fpu_rslt;

   logic             slot_free, req_fire;
   logic [IDX_W-1:0] n_clamp;
   logic             piv_nan, thr_nan, piv_small;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      addr_of = {r[POS_W-1:0], c[POS_W-1:0]};
   endfunction

   luf_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .cmd   (fpu_cmd),
      .rslt  (fpu_rslt)
   );

   // handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // order clamp and pivot test
   always_comb begin
      n_clamp   = (size_ff > IDX_W'(MAX_DIM)) ? IDX_W'(MAX_DIM) : size_ff;
      piv_nan   = (rdata_ff[62:52] == 11'h7FF) && (rdata_ff[51:0] != 52'd0);
      thr_nan   = (thresh_ff[62:52] == 11'h7FF) && (thresh_ff[51:0] != 52'd0);
      piv_small = spen_ff && !piv_nan && !thr_nan && !thresh_ff[63]
                  && ({1'b0, rdata_ff[62:0]} < thresh_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = addr_of(i_ff, j_ff);
      mem_wd       = fpu_rslt.value;
      mem_re       = 1'b0;
      mem_ra       = addr_of(i_ff, j_ff);
      fpu_cmd.start = 1'b0;
      fpu_cmd.op    = OP_MUL;
      fpu_cmd.a     = rdata_ff;
      fpu_cmd.b     = r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.func)
                  FN_WRITE: begin
                     mem_we       = 1'b1;
                     mem_wa       = {req_data.row, req_data.col};
                     mem_wd       = req_data.value;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{read_value: 64'd0, replaced_pivots: cnt_ff};
                  end
                  FN_READ: begin
                     mem_re   = 1'b1;
                     mem_ra   = {req_data.row, req_data.col};
                     state_in = ST_RD_WAIT;
                  end
                  FN_FACTOR: begin
                     n_in = n_clamp;
                     j_in = '0;
                     if (n_clamp == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{read_value: 64'd0, replaced_pivots: cnt_ff};
                     end else begin
                        state_in = ST_PIV_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{read_value: 64'd0, replaced_pivots: cnt_ff};
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{read_value: rdata_ff, replaced_pivots: cnt_ff};
               state_in     = ST_IDLE;
            end
         end
         // pivot fetch, static replacement and reciprocal
         ST_PIV_RD: begin
            mem_re   = 1'b1;
            mem_ra   = addr_of(j_ff, j_ff);
            state_in = ST_PIV_CHK;
         end
         ST_PIV_CHK: begin
            fpu_cmd.start = 1'b1;
            fpu_cmd.op    = OP_RCP;
            if (piv_small) begin
               fpu_cmd.a = thresh_ff;
               mem_we    = 1'b1;
               mem_wa    = addr_of(j_ff, j_ff);
               mem_wd    = thresh_ff;
               if (cnt_ff != CNT_MAX) begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
            state_in = ST_RCP_WAIT;
         end
         ST_RCP_WAIT: begin
            if (fpu_rslt.done) begin
               r_in = fpu_rslt.value;
               i_in = j_ff + 7'd1;
               state_in = ((j_ff + 7'd1) < n_ff) ? ST_L_RD : ST_COL_NEXT;
            end
         end
         // scale the column below the diagonal
         ST_L_RD: begin
            mem_re   = 1'b1;
            mem_ra   = addr_of(i_ff, j_ff);
            state_in = ST_L_GO;
         end
         ST_L_GO: begin
            fpu_cmd.start = 1'b1;
            state_in      = ST_L_WAIT;
         end
         ST_L_WAIT: begin
            if (fpu_rslt.done) begin
               mem_we = 1'b1;
               mem_wa = addr_of(i_ff, j_ff);
               if ((i_ff + 7'd1) < n_ff) begin
                  i_in     = i_ff + 7'd1;
                  state_in = ST_L_RD;
               end else begin
                  l_in     = j_ff + 7'd1;
                  state_in = ST_U_RD;
               end
            end
         end
         // rank-one update, one column of the trailing part at a time
         ST_U_RD: begin
            mem_re   = 1'b1;
            mem_ra   = addr_of(j_ff, l_ff);
            state_in = ST_U_GET;
         end
         ST_U_GET: begin
            u_in     = rdata_ff;
            i_in     = j_ff + 7'd1;
            state_in = ST_P_RD;
         end
         ST_P_RD: begin
            mem_re   = 1'b1;
            mem_ra   = addr_of(i_ff, j_ff);
            state_in = ST_P_GO;
         end
         ST_P_GO: begin
            fpu_cmd.start = 1'b1;
            fpu_cmd.b     = u_ff;
            state_in      = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (fpu_rslt.done) begin
               p_in     = fpu_rslt.value;
               state_in = ST_A_RD;
            end
         end
         ST_A_RD: begin
            mem_re   = 1'b1;
            mem_ra   = addr_of(i_ff, l_ff);
            state_in = ST_A_GO;
         end
         ST_A_GO: begin
            fpu_cmd.start = 1'b1;
            fpu_cmd.op    = OP_SUB;
            fpu_cmd.b     = p_ff;
            state_in      = ST_A_WAIT;
         end
         ST_A_WAIT: begin
            if (fpu_rslt.done) begin
               mem_we = 1'b1;
               mem_wa = addr_of(i_ff, l_ff);
               if ((i_ff + 7'd1) < n_ff) begin
                  i_in     = i_ff + 7'd1;
                  state_in = ST_P_RD;
               end else if ((l_ff + 7'd1) < n_ff) begin
                  l_in     = l_ff + 7'd1;
                  state_in = ST_U_RD;
               end else begin
                  state_in = ST_COL_NEXT;
               end
            end
         end
         ST_COL_NEXT: begin
            if ((j_ff + 7'd1) < n_ff) begin
               j_in     = j_ff + 7'd1;
               state_in = ST_PIV_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{read_value: 64'd0, replaced_pivots: cnt_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      u_ff        <= u_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= IDX_W'(MAX_DIM);
         thresh_ff <= 64'd0;
         spen_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE:   size_ff   <= csr_data[IDX_W-1:0];
            CSR_THRESH: thresh_ff <= csr_data;
            CSR_ENABLE: spen_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // matrix store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

`ifndef SYNTHESIS
   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      cnt_ff >= $past(cnt_ff))
      else $error("pivot count decreased");

   a_cnt_src: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> ($past(state_ff) == ST_PIV_CHK))
      else $error("pivot count changed outside pivot check");

   a_idle_wr: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == ST_IDLE)) |-> req_fire)
      else $error("store written while idle without a write word");

   a_fpu_done: assert property (@(posedge clock) disable iff (reset)
      fpu_rslt.done |-> (state_ff == ST_RCP_WAIT || state_ff == ST_L_WAIT
                         || state_ff == ST_P_WAIT || state_ff == ST_A_WAIT))
      else $error("arithmetic result arrived outside a wait state");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for the static-pivot LU engine, predicting every response word
// depends on luf_pkg and lu_factorization_static_pivot
`default_nettype none

module tb;
   import luf_pkg::*;

   localparam int TARGET_WORDS = 1700;
   localparam int CALM_WORDS   = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   luf_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   luf_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SIZE;
   logic [63:0] csr_data = '0;

   // shadow of the block: store, registers and pivot count
   logic [63:0] lu_store [MAX_DIM][MAX_DIM];
   bit          was_written [MAX_DIM][MAX_DIM];
   logic [6:0]  size_reg = 7'd64;
   logic [63:0] thresh_reg = '0;
   logic        enable_reg = 1'b1;
   logic [6:0]  pivots_seen = '0;

   luf_rsp_type pending_rsp[$];
   int          words_sent = 0;
   int          mismatches = 0;
   bit          idle_on = 1'b1;
   bit          hold_tgl = 1'b0;

   lu_factorization_static_pivot uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // right-looking elimination over the leading part of the shadow store
   function automatic void factor_store();
      int n;
      real crit, r, u, p;
      logic [63:0] pb;
      n = size_reg;
      if (n > MAX_DIM) n = MAX_DIM;
      crit = $bitstoreal(thresh_reg);
      for (int j = 0; j < n; j++) begin
         pb = lu_store[j][j];
         if (enable_reg && $bitstoreal({1'b0, pb[62:0]}) < crit) begin
            pb = thresh_reg;
            lu_store[j][j] = pb;
            if (pivots_seen < CNT_MAX) pivots_seen++;
         end
         // reciprocal of a signed zero is a signed infinity
         if ($bitstoreal(pb) == 0.0) r = $bitstoreal({pb[63], 11'h7FF, 52'h0});
         else r = 1.0 / $bitstoreal(pb);
         for (int i = j + 1; i < n; i++)
            lu_store[i][j] = $realtobits($bitstoreal(lu_store[i][j]) * r);
         for (int l = j + 1; l < n; l++) begin
            u = $bitstoreal(lu_store[j][l]);
            for (int i = j + 1; i < n; i++) begin
               p = $bitstoreal(lu_store[i][j]) * u;
               lu_store[i][l] = $realtobits($bitstoreal(lu_store[i][l]) - p);
            end
         end
      end
   endfunction

   function automatic luf_rsp_type predict_word(luf_req_type w);
      luf_rsp_type o;
      o = '0;
      case (w.func)
         FN_WRITE: begin
            lu_store[w.row][w.col] = w.value;
            was_written[w.row][w.col] = 1'b1;
         end
         FN_FACTOR: factor_store();
         FN_READ: o.read_value = lu_store[w.row][w.col];
         default: ;
      endcase
      o.replaced_pivots = pivots_seen;
      return o;
   endfunction

   // random element: mostly moderate values, some zeros, tiny and raw patterns
   function automatic logic [63:0] rand_elem();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = {v[63], 63'h0};
         1: ;
         2: v = {v[63], 11'h000, v[51:0]};
         3: v = {v[63], 11'd1000, v[51:0]};
         default: v = {v[63], 11'd1023 + 11'($urandom_range(0, 4)) - 11'd2, v[51:0]};
      endcase
      return v;
   endfunction

   function automatic luf_req_type make_word(logic [1:0] f, int r, int c, logic [63:0] v);
      luf_req_type w;
      w.func = f;
      w.row = 6'(r);
      w.col = 6'(c);
      w.value = v;
      return w;
   endfunction

   // offer one word, hold it until taken, then queue its expectation
   task automatic send_word(input luf_req_type w, input bit typed, input luf_rsp_type want);
      luf_rsp_type guess;
      int gap;
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      guess = predict_word(w);
      pending_rsp.push_back(typed ? want : guess);
      words_sent++;
      if (words_sent > CALM_WORDS) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send(input luf_req_type w);
      send_word(w, 1'b0, '0);
   endtask

   // stop offering and wait for every outstanding response word
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] d);
      drain();
      csr_index <= idx;
      csr_data <= d;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SIZE: size_reg = d[6:0];
         CSR_THRESH: thresh_reg = d;
         CSR_ENABLE: enable_reg = d[0];
         default: ;
      endcase
   endtask

   // one random phase: load leading block, then factorise and read back, or only read eight elements; with noise
   task automatic run_phase(input int n, input bit do_factor, input bit squeeze);
      int r, c, lim;
      lim = (n > MAX_DIM) ? MAX_DIM : n;
      if (squeeze) hold_tgl <= ~hold_tgl;
      for (int i = 0; i < lim; i++)
         for (int k = 0; k < lim; k++) begin
            send(make_word(FN_WRITE, i, k, rand_elem()));
            if ($urandom_range(0, 7) == 0) begin
               r = $urandom_range(0, 63);
               c = $urandom_range(0, 63);
               if ($urandom_range(0, 1) == 0 || !was_written[r][c])
                  send(make_word(FN_WRITE, r, c, {$urandom, $urandom}));
               else
                  send(make_word(FN_READ, r, c, {$urandom, $urandom}));
            end
            if ($urandom_range(0, 15) == 0)
               send(make_word(2'd3, $urandom_range(0, 63), $urandom_range(0, 63),
                              {$urandom, $urandom}));
         end
      if (do_factor) begin
         repeat ($urandom_range(1, 2)) send(make_word(FN_FACTOR, $urandom_range(0, 63),
                                                     $urandom_range(0, 63), {$urandom, $urandom}));
         for (int i = 0; i < lim; i++)
            for (int k = 0; k < lim; k++)
               send(make_word(FN_READ, i, k, {$urandom, $urandom}));
      end else begin
         repeat (8) begin
            r = $urandom_range(0, lim - 1);
            c = $urandom_range(0, lim - 1);
            send(make_word(FN_READ, r, c, '0));
         end
      end
   endtask

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin : receiver
      int stall_left;
      bit seen_tgl;
      if (hold_tgl != seen_tgl) begin
         seen_tgl = hold_tgl;
         stall_left = 300;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each taken response word with the oldest expectation
   always @(posedge clock) begin
      luf_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value ||
                rsp_data.replaced_pivots !== want.replaced_pivots) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value exp %h got %h, pivots exp %0d got %0d",
                           want.read_value, rsp_data.read_value,
                           want.replaced_pivots, rsp_data.replaced_pivots);
            end
         end
      end
   end

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      luf_req_type w;
      bit          typed;
      luf_rsp_type want;
   } step_type;

   initial begin : stimulus
      step_type plan[$];
      int n;
      logic [63:0] th;
      for (int i = 0; i < MAX_DIM; i++)
         for (int k = 0; k < MAX_DIM; k++) begin
            lu_store[i][k] = '0;
            was_written[i][k] = 1'b0;
         end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, unused code, zero pivot, replaced pivot
      plan = '{
         '{1, CSR_SIZE, '0, 0, '0},
         '{0, 0, make_word(FN_WRITE, 0, 0, 64'h0), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_WRITE, 0, 1, 64'h4000_0000_0000_0000), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_WRITE, 1, 0, 64'h4008_0000_0000_0000), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_WRITE, 1, 1, 64'h4010_0000_0000_0000), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_WRITE, 63, 63, '1), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_WRITE, 63, 0, 64'h8000_0000_0000_0000), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_READ, 63, 63, '0), 1, '{'1, 7'd0}},
         '{0, 0, make_word(FN_READ, 63, 0, '1), 1, '{64'h8000_0000_0000_0000, 7'd0}},
         '{0, 0, make_word(FN_READ, 0, 1, '0), 1, '{64'h4000_0000_0000_0000, 7'd0}},
         '{0, 0, make_word(2'd3, 63, 63, '1), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_FACTOR, 0, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 0, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 1, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 1, 1, '0), 0, '0},
         '{1, CSR_THRESH, '0, 0, '0},
         '{0, 0, make_word(FN_WRITE, 0, 0, 64'h3FE0_0000_0000_0000), 1, '{64'h0, 7'd0}},
         '{0, 0, make_word(FN_FACTOR, 0, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 0, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 1, 1, '0), 0, '0},
         '{1, CSR_ENABLE, '0, 0, '0},
         '{0, 0, make_word(FN_WRITE, 0, 0, 64'h0), 0, '0},
         '{0, 0, make_word(FN_FACTOR, 0, 0, '0), 0, '0},
         '{0, 0, make_word(FN_READ, 0, 0, '0), 0, '0}
      };
      foreach (plan[s]) begin
         if (plan[s].is_csr) begin
            case (plan[s].idx)
               CSR_SIZE: csr_write(CSR_SIZE, 64'd2);
               CSR_THRESH: csr_write(CSR_THRESH, 64'h3FF0_0000_0000_0000);
               default: csr_write(CSR_ENABLE, 64'd0);
            endcase
         end else begin
            send_word(plan[s].w, plan[s].typed, plan[s].want);
         end
      end

      // size beyond the store and the full store: load and read, no factorise; then a factorise of order zero
      csr_write(CSR_SIZE, 64'd127);
      run_phase(3, 1'b0, 1'b1);
      csr_write(CSR_SIZE, 64'd64);
      run_phase(4, 1'b0, 1'b0);
      csr_write(CSR_SIZE, 64'd0);
      send(make_word(FN_FACTOR, 0, 0, '0));
      send(make_word(FN_READ, 0, 0, '0));

      // random phases over sizes, thresholds and enable
      while (words_sent < TARGET_WORDS) begin
         n = $urandom_range(1, 6);
         case ($urandom_range(0, 8))
            0: th = 64'h0;
            1: th = 64'h3FF0_0000_0000_0000;
            2: th = 64'h3F50_624D_D2F1_A9FC;
            3: th = 64'h7FF0_0000_0000_0000;
            4: th = 64'h7FF8_0000_0000_0000;
            5: th = 64'hBFF0_0000_0000_0000;
            6: th = 64'h7FEF_FFFF_FFFF_FFFF;
            7: th = '1;
            default: th = {$urandom, $urandom};
         endcase
         csr_write(CSR_SIZE, {$urandom, 25'h0, 7'(n)} & 64'h7F);
         csr_write(CSR_THRESH, th);
         csr_write(CSR_ENABLE, {63'h0, ($urandom_range(0, 3) != 0)});
         run_phase(n, 1'b1, ($urandom_range(0, 9) == 0));
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("** lu_factorization_static_pivot: PASSED **");
      end else begin
         $display("** lu_factorization_static_pivot: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #40000000;
      $display("** lu_factorization_static_pivot: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/luf_pkg.sv
rtl/core/luf_fpu.sv
rtl/core/lu_factorization_static_pivot.sv
test/tb.sv
